### rtl/core/dtt_pkg.sv
// Shared types, request and status codes, and sizing constants for the deadline timer table.
package dtt_pkg;

  // Table size and tick fan-out limit.
  localparam int NUM_SLOTS = 16;
  localparam int MAX_FIRES = 16;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(MAX_FIRES + 1);
  localparam int TIME_W    = 48;
  localparam int DELAY_W   = 32;

  // Request codes.
  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_SET    = 3'd1;
  localparam logic [2:0] REQ_ADD    = 3'd2;
  localparam logic [2:0] REQ_REMOVE = 3'd3;
  localparam logic [2:0] REQ_UPDATE = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ACTIVE     = 2'd1;
  localparam logic [1:0] ST_FIRED      = 2'd2;
  localparam logic [1:0] ST_NOT_ACTIVE = 2'd3;

  // One input request.
  typedef struct packed {
    logic [2:0]         req_type;
    logic [3:0]         slot_id;
    logic [DELAY_W-1:0] delay_ms;
    logic [TIME_W-1:0]  now_ms;
  } in_req_t;

  // One result.
  typedef struct packed {
    logic [1:0] status;
    logic       fired_valid;
    logic [3:0] fired_slot;
    logic       last;
  } out_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic scan_step;
    logic scan_flush;
  } dtt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_is_tick;
    logic out_free;
    logic idx_last;
  } dtt_stat_t;

endpackage

### rtl/core/dtt_ctrl.sv
// Controller state machine that sequences single-slot requests and tick scans.
module dtt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dtt_pkg::dtt_stat_t  stat,
  output dtt_pkg::dtt_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Requests are taken only between items.
  assign in_stall = (state_r != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt      = state_r;
    cmd.load       = 1'b0;
    cmd.exec       = 1'b0;
    cmd.scan_step  = 1'b0;
    cmd.scan_flush = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.in_is_tick ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.out_free) begin
          cmd.scan_step = 1'b1;
          if (stat.idx_last) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.scan_flush = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/dtt_datapath.sv
// Datapath holding the slot table, the scan counter, the pending fire and the result register.
module dtt_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  dtt_pkg::in_req_t    in_data,
  input  dtt_pkg::dtt_cmd_t   cmd,
  output dtt_pkg::dtt_stat_t  stat,
  output logic                out_valid,
  input  logic                out_stall,
  output dtt_pkg::out_res_t   out_data
);

  localparam int IDX_W  = dtt_pkg::IDX_W;
  localparam int CNT_W  = dtt_pkg::CNT_W;
  localparam int TIME_W = dtt_pkg::TIME_W;

  // Slot table.
  logic [dtt_pkg::NUM_SLOTS-1:0] active_r;
  logic [dtt_pkg::NUM_SLOTS-1:0] active_nxt;
  logic [TIME_W-1:0]             deadline_r [dtt_pkg::NUM_SLOTS];
  logic                          dl_we;
  logic [TIME_W-1:0]             dl_wdata;

  // Captured request.
  dtt_pkg::in_req_t req_r;

  // Scan state.
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             pend_v_r;
  logic             pend_v_nxt;
  logic [IDX_W-1:0] pend_slot_r;
  logic [IDX_W-1:0] pend_slot_nxt;

  // Result register.
  logic               out_valid_r;
  dtt_pkg::out_res_t  out_data_r;
  logic               emit;
  dtt_pkg::out_res_t  emit_data;

  // Single-slot request arithmetic.
  logic [IDX_W-1:0]  slot_idx;
  logic              slot_in_range;
  logic [TIME_W:0]   dl_sum;
  logic [TIME_W-1:0] dl_sat;
  logic              cur_due;
  logic              sat_due;
  logic              scan_hit;

  assign slot_idx      = IDX_W'(req_r.slot_id);
  assign slot_in_range = (int'(req_r.slot_id) < dtt_pkg::NUM_SLOTS);
  assign dl_sum        = {1'b0, req_r.now_ms} + (TIME_W + 1)'(req_r.delay_ms);
  assign dl_sat        = dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];
  assign cur_due       = (deadline_r[slot_idx] <= req_r.now_ms);
  assign sat_due       = (dl_sat <= req_r.now_ms);

  // A slot fires on tick when armed, due, and the per-tick limit is not reached.
  assign scan_hit = active_r[idx_r] && (deadline_r[idx_r] <= req_r.now_ms) &&
                    (cnt_r < CNT_W'(dtt_pkg::MAX_FIRES));

  // Status to the controller.
  assign stat.in_is_tick = (in_data.req_type == dtt_pkg::REQ_TICK);
  assign stat.out_free   = !out_valid_r || !out_stall;
  assign stat.idx_last   = (idx_r == IDX_W'(dtt_pkg::NUM_SLOTS - 1));

  // Table updates and result generation.
  always_comb begin
    active_nxt    = active_r;
    dl_we         = 1'b0;
    dl_wdata      = dl_sat;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    emit          = 1'b0;
    emit_data     = '{status: dtt_pkg::ST_OK, fired_valid: 1'b0, fired_slot: 4'd0,
                      last: 1'b1};

    if (cmd.load) begin
      // A new request restarts the scan bookkeeping.
      idx_nxt    = '0;
      cnt_nxt    = '0;
      pend_v_nxt = 1'b0;
    end

    if (cmd.exec) begin
      emit = 1'b1;
      priority if (req_r.req_type > dtt_pkg::REQ_UPDATE) begin
        emit_data.status = dtt_pkg::ST_OK;
      end else if (!slot_in_range) begin
        emit_data.status = dtt_pkg::ST_NOT_ACTIVE;
      end else if (req_r.req_type == dtt_pkg::REQ_SET) begin
        dl_we            = 1'b1;
        emit_data.status = dtt_pkg::ST_OK;
      end else if (req_r.req_type == dtt_pkg::REQ_ADD) begin
        if (active_r[slot_idx]) begin
          emit_data.status = dtt_pkg::ST_ACTIVE;
        end else if (cur_due) begin
          emit_data.status      = dtt_pkg::ST_FIRED;
          emit_data.fired_valid = 1'b1;
          emit_data.fired_slot  = req_r.slot_id;
        end else begin
          active_nxt[slot_idx] = 1'b1;
          emit_data.status     = dtt_pkg::ST_OK;
        end
      end else if (req_r.req_type == dtt_pkg::REQ_REMOVE) begin
        if (active_r[slot_idx]) begin
          active_nxt[slot_idx] = 1'b0;
          emit_data.status     = dtt_pkg::ST_OK;
        end else begin
          emit_data.status = dtt_pkg::ST_NOT_ACTIVE;
        end
      end else begin
        // Update: disarm, store the new deadline, then add against it.
        dl_we = 1'b1;
        if (sat_due) begin
          active_nxt[slot_idx]  = 1'b0;
          emit_data.status      = dtt_pkg::ST_FIRED;
          emit_data.fired_valid = 1'b1;
          emit_data.fired_slot  = req_r.slot_id;
        end else begin
          active_nxt[slot_idx] = 1'b1;
          emit_data.status     = dtt_pkg::ST_OK;
        end
      end
    end

    if (cmd.scan_step) begin
      // Each hit pushes out the previous one, so the final hit can carry last.
      idx_nxt = idx_r + IDX_W'(1);
      if (scan_hit) begin
        active_nxt[idx_r] = 1'b0;
        cnt_nxt           = cnt_r + CNT_W'(1);
        pend_v_nxt        = 1'b1;
        pend_slot_nxt     = idx_r;
        if (pend_v_r) begin
          emit                  = 1'b1;
          emit_data.fired_valid = 1'b1;
          emit_data.fired_slot  = 4'(pend_slot_r);
          emit_data.last        = 1'b0;
        end
      end
    end

    if (cmd.scan_flush) begin
      // Final tick result: the held hit, or a plain result when nothing fired.
      emit       = 1'b1;
      pend_v_nxt = 1'b0;
      if (pend_v_r) begin
        emit_data.fired_valid = 1'b1;
        emit_data.fired_slot  = 4'(pend_slot_r);
      end
    end
  end

  // Control state and the slot table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
      for (int i = 0; i < dtt_pkg::NUM_SLOTS; i++) begin
        deadline_r[i] <= '0;
      end
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= emit | (out_valid_r & out_stall);
      pend_v_r    <= pend_v_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      if (dl_we) begin
        deadline_r[slot_idx] <= dl_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    pend_slot_r <= pend_slot_nxt;
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/deadline_timer_table_core.sv
// Top level of the deadline timer table: controller plus datapath.
//
// A table of NUM_SLOTS timer slots, each with an armed mark and a 48-bit
// absolute deadline in milliseconds. One request is handled at a time. Set,
// add, remove, update and unknown requests each give one result. A tick
// walks the table one slot per cycle while the result register has room,
// through a single deadline comparator, and gives one result per fired
// slot (lowest slot first, at most MAX_FIRES) or one plain result when
// none fired; the last result is marked. The next request is accepted as
// soon as the previous one has handed its final result to the result
// register, even if that result has not yet been taken.
module deadline_timer_table_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dtt_pkg::in_req_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dtt_pkg::out_res_t  out_data
);

  dtt_pkg::dtt_cmd_t  cmd;
  dtt_pkg::dtt_stat_t stat;

  // Sequencer.
  dtt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Table and result path.
  dtt_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
